// File: design/tpds_pkg.sv
// ----------------------------------------------------------------------------
// Thermal packet deframer package
// Shared constants, register indexes and types for the packet deframer and
// gray scaler.
// ----------------------------------------------------------------------------
package tpds_pkg;

	localparam int PACKET_BYTES     = 164;
	localparam int PACKETS_IN_FRAME = 60;
	localparam int HEADER_BYTES     = 4;

	localparam int POS_W   = $clog2(PACKET_BYTES);
	localparam int EXP_W   = (PACKETS_IN_FRAME > 1) ? $clog2(PACKETS_IN_FRAME) : 1;
	localparam int BYTE_W  = 8;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 7;
	localparam int GRAY_W  = 8;
	localparam int LEVEL_W = 16;
	localparam int PIX_W   = 2 * BYTE_W;

	localparam int LAST_ROW    = PACKETS_IN_FRAME - 1;
	localparam int LAST_COLUMN = (PACKET_BYTES - HEADER_BYTES) / 2 - 1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLACK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 1'b1;

	localparam logic [LEVEL_W-1:0] BLACK_RESET = 16'd7800;
	localparam logic [LEVEL_W-1:0] WHITE_RESET = 16'd10000;
	localparam logic [GRAY_W-1:0]  GRAY_MAX    = 8'd255;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic               resync;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   column;
		logic               frame_end;
		logic [PIX_W-1:0]   pixel;
	} work_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] black;
		logic [LEVEL_W-1:0] white;
	} levels_t;

endpackage

// File: design/tpds_byte_if.sv
// ----------------------------------------------------------------------------
// Serial byte channel
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface tpds_byte_if;
	import tpds_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] spi_byte;

	modport source (output valid, output spi_byte, input ready);
	modport sink (input valid, input spi_byte, output ready);
	modport monitor (input valid, input spi_byte, input ready);
endinterface

// File: design/tpds_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel that carries one scaled pixel or resync report per
// transaction.
// ----------------------------------------------------------------------------
interface tpds_pixel_if;
	import tpds_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  column;
	logic [GRAY_W-1:0] gray;
	logic              frame_end;
	logic              resync;

	modport source (output valid, output row, output column, output gray,
		output frame_end, output resync, input ready);
	modport sink (input valid, input row, input column, input gray,
		input frame_end, input resync, output ready);
	modport monitor (input valid, input row, input column, input gray,
		input frame_end, input resync, input ready);
endinterface

// File: design/tpds_front.sv
// ----------------------------------------------------------------------------
// Packet deframer front end
// Tracks the byte position in each packet, checks packet numbers, pairs
// payload bytes into pixels and queues pixel and resync work items.
// ----------------------------------------------------------------------------
module tpds_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tpds_byte_if.sink            bytes,
	input  logic                 full,
	output logic                 push,
	output tpds_pkg::work_item_t item
);
	import tpds_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [EXP_W-1:0]  exp_q;
	logic              acc_q;
	logic [BYTE_W-1:0] held_q;

	logic              take;
	logic [POS_W-1:0]  off;
	logic              match;
	logic              is_check;
	logic              is_payload;
	logic              last_byte;
	logic              last_packet;

	assign bytes.ready = !full;
	assign take        = bytes.valid && !full;
	assign off         = pos_q - POS_W'(HEADER_BYTES);
	assign match       = bytes.spi_byte == BYTE_W'(exp_q);
	assign is_check    = pos_q == POS_W'(1);
	assign is_payload  = pos_q >= POS_W'(HEADER_BYTES);
	assign last_byte   = pos_q == POS_W'(PACKET_BYTES - 1);
	assign last_packet = exp_q == EXP_W'(LAST_ROW);

	always_comb begin
		push = 1'b0;
		item = '0;
		if (take) begin
			if (is_check && !match) begin
				push        = 1'b1;
				item.resync = 1'b1;
			end else if (is_payload && off[0] && acc_q) begin
				push           = 1'b1;
				item.row       = ROW_W'(exp_q);
				item.column    = COL_W'(off >> 1);
				item.frame_end = (pos_q >= POS_W'(PACKET_BYTES - 2)) && last_packet;
				item.pixel     = {held_q, bytes.spi_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			exp_q <= '0;
			acc_q <= 1'b0;
		end else if (take) begin
			if (is_check) begin
				if (match) begin
					acc_q <= 1'b1;
				end else begin
					acc_q <= 1'b0;
					exp_q <= '0;
				end
			end
			if (last_byte) begin
				pos_q <= '0;
				acc_q <= 1'b0;
				if (acc_q) begin
					exp_q <= last_packet ? '0 : exp_q + EXP_W'(1);
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_payload && !off[0]) begin
			held_q <= bytes.spi_byte;
		end
	end
endmodule

// File: design/tpds_fifo.sv
// ----------------------------------------------------------------------------
// Work item queue
// Short first-in first-out queue that decouples the deframer from the
// gray scaler.
// ----------------------------------------------------------------------------
module tpds_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tpds_pkg::work_item_t wr_item,
	input  logic                 pop,
	output tpds_pkg::work_item_t head,
	output logic                 full,
	output logic                 empty
);
	import tpds_pkg::*;

	work_item_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW + 1)'(1);
			end
		end
	end
endmodule

// File: design/tpds_back.sv
// ----------------------------------------------------------------------------
// Gray scaler back end
// Takes queued work items, clamps or divides each pixel into an 8-bit gray
// level two quotient bits per cycle, and holds the result for the sink.
// ----------------------------------------------------------------------------
module tpds_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpds_pkg::levels_t    levels,
	input  logic                 empty,
	input  tpds_pkg::work_item_t head,
	output logic                 pop,
	tpds_pixel_if.source         pixels
);
	import tpds_pkg::*;

	localparam int DIV_CYCLES = GRAY_W / 2;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]              state_q;
	work_item_t              item_q;
	logic [GRAY_W-1:0]       gray_q;
	logic [LEVEL_W-1:0]      rem_q;
	logic [GRAY_W-1:0]       lo_q;
	logic [LEVEL_W-1:0]      span_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;

	logic [LEVEL_W-1:0]      diff;
	logic [LEVEL_W+GRAY_W-1:0] prod;
	logic [LEVEL_W:0]        trial;
	logic [LEVEL_W-1:0]      rem_nx;
	logic [GRAY_W-1:0]       lo_nx;
	logic [GRAY_W-1:0]       quo_nx;
	logic                    load_out;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign load_out = (state_q == ST_WAIT) && (!out_valid_q || pixels.ready);
	assign diff     = head.pixel - levels.black;
	assign prod     = {diff, GRAY_W'(0)} - (LEVEL_W + GRAY_W)'(diff);

	always_comb begin
		rem_nx = rem_q;
		lo_nx  = lo_q;
		quo_nx = gray_q;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_nx, lo_nx[GRAY_W-1]};
			lo_nx = {lo_nx[GRAY_W-2:0], 1'b0};
			if (trial >= {1'b0, span_q}) begin
				rem_nx = LEVEL_W'(trial - {1'b0, span_q});
				quo_nx = {quo_nx[GRAY_W-2:0], 1'b1};
			end else begin
				rem_nx = trial[LEVEL_W-1:0];
				quo_nx = {quo_nx[GRAY_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.resync || head.pixel <= levels.black
								|| head.pixel >= levels.white) begin
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_DIV;
							cnt_q   <= '0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
			span_q <= levels.white - levels.black;
			rem_q  <= prod[LEVEL_W+GRAY_W-1:GRAY_W];
			lo_q   <= prod[GRAY_W-1:0];
			if (head.resync || head.pixel <= levels.black) begin
				gray_q <= '0;
			end else if (head.pixel >= levels.white) begin
				gray_q <= GRAY_MAX;
			end else begin
				gray_q <= '0;
			end
		end else if (state_q == ST_DIV) begin
			rem_q  <= rem_nx;
			lo_q   <= lo_nx;
			gray_q <= quo_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixels.row       <= item_q.row;
			pixels.column    <= item_q.column;
			pixels.frame_end <= item_q.frame_end;
			pixels.resync    <= item_q.resync;
			pixels.gray      <= gray_q;
		end
	end

	assign pixels.valid = out_valid_q;
endmodule

// File: design/thermal_packet_deframer_scaler.sv
// ----------------------------------------------------------------------------
// Thermal packet deframer and gray scaler
// Cuts the camera byte stream into packets, checks packet numbers and maps
// each 16-bit pixel linearly onto an 8-bit gray level.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle while its four-entry queue has room.
// Each pixel result passes through the back end as a queue pop, the steps of
// the two-bit-per-cycle divider and an output load; a clamped pixel or resync
// report skips the divider. The back end pops a new work item only after it
// has loaded the result of the last one. Packet-number mismatches produce a
// resync transaction with all pixel fields zero.
module thermal_packet_deframer_scaler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tpds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpds_pkg::LEVEL_W-1:0]  cfg_data,
	tpds_byte_if.sink                     bytes,
	tpds_pixel_if.source                  pixels
);
	import tpds_pkg::*;

	levels_t    levels_q;
	work_item_t push_item;
	work_item_t head;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.black <= BLACK_RESET;
			levels_q.white <= WHITE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLACK: levels_q.black <= cfg_data;
				CFG_WHITE: levels_q.white <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpds_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.full   (full),
		.push   (push),
		.item   (push_item)
	);

	tpds_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	tpds_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.levels (levels_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.pixels (pixels)
	);
endmodule

// File: design/tpds_checker.sv
// ----------------------------------------------------------------------------
// Thermal packet deframer checker
// Watches the result channel of the deframer and checks the field relations
// that every transaction must keep.
// ----------------------------------------------------------------------------
module tpds_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic                         ready,
	input logic [tpds_pkg::ROW_W-1:0]  row,
	input logic [tpds_pkg::COL_W-1:0]  column,
	input logic [tpds_pkg::GRAY_W-1:0] gray,
	input logic                         frame_end,
	input logic                         resync
);
	import tpds_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(gray)
			&& $stable(row) && $stable(column)
			&& $stable(resync) && $stable(frame_end))
		else $error("Result changed while stalled.");

	a_resync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && resync |-> row == '0 && column == '0
			&& gray == '0 && !frame_end)
		else $error("Resync transaction carries pixel data.");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && frame_end |-> !resync
			&& row == ROW_W'(LAST_ROW) && column == COL_W'(LAST_COLUMN))
		else $error("Frame end flagged away from the last pixel.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> row <= ROW_W'(LAST_ROW)
			&& column <= COL_W'(LAST_COLUMN))
		else $error("Row or column out of range.");
endmodule

bind thermal_packet_deframer_scaler tpds_checker u_tpds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (pixels.valid),
	.ready     (pixels.ready),
	.row       (pixels.row),
	.column    (pixels.column),
	.gray      (pixels.gray),
	.frame_end (pixels.frame_end),
	.resync    (pixels.resync)
);

// File: test/thermal_packet_deframer_scaler_tb.sv
// ----------------------------------------------------------------------------
// Thermal packet deframer and gray scaler testbench
// Sends 164-byte camera packets with good and bad packet numbers through the
// byte channel. It keeps a running model of the packet state and the gray
// levels, and checks every pixel and resync transaction against that model.
// Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module thermal_packet_deframer_scaler_tb;
	import tpds_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 700;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [GRAY_W-1:0] gray;
		logic              frame_end;
		logic              resync;
	} pixel_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEVEL_W-1:0]   cfg_data;

	tpds_byte_if  byte_ch();
	tpds_pixel_if pixel_ch();

	thermal_packet_deframer_scaler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (byte_ch),
		.pixels    (pixel_ch)
	);

	pixel_result_t pending_pixels[$];
	int errors = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int ready_hold = 0;
	bit jitter_on = 1'b1;

	int               frm_pos;
	int               frm_expect;
	bit               frm_ok;
	logic [7:0]       frm_high;
	logic [LEVEL_W-1:0] lvl_black;
	logic [LEVEL_W-1:0] lvl_white;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (!jitter_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [GRAY_W-1:0] scale_gray(input logic [15:0] p);
		int unsigned span;
		int unsigned num;
		if (p <= lvl_black) begin
			return '0;
		end
		if (p >= lvl_white) begin
			return GRAY_MAX;
		end
		span = 32'(lvl_white) - 32'(lvl_black);
		num = (32'(p) - 32'(lvl_black)) * 32'(GRAY_MAX);
		return GRAY_W'(num / span);
	endfunction

	function automatic void model_byte(input logic [7:0] b);
		pixel_result_t r;
		int off;
		r = '0;
		if (frm_pos == 1) begin
			if (b == frm_expect) begin
				frm_ok = 1'b1;
			end else begin
				frm_ok = 1'b0;
				frm_expect = 0;
				r.resync = 1'b1;
				pending_pixels.push_back(r);
			end
		end else if (frm_pos >= HEADER_BYTES) begin
			off = frm_pos - HEADER_BYTES;
			if (off % 2 == 0) begin
				frm_high = b;
			end else if (frm_ok) begin
				r.row = ROW_W'(frm_expect);
				r.column = COL_W'(off / 2);
				r.gray = scale_gray({frm_high, b});
				r.frame_end = (frm_pos + 2 >= PACKET_BYTES) &&
					(frm_expect + 1 >= PACKETS_IN_FRAME);
				pending_pixels.push_back(r);
			end
		end
		frm_pos++;
		if (frm_pos >= PACKET_BYTES) begin
			frm_pos = 0;
			if (frm_ok) begin
				frm_expect = (frm_expect + 1 >= PACKETS_IN_FRAME) ? 0 : frm_expect + 1;
			end
			frm_ok = 1'b0;
		end
	endfunction

	function automatic logic [15:0] pick_pixel();
		int lo;
		int hi;
		lo = (lvl_black < lvl_white) ? lvl_black : lvl_white;
		hi = (lvl_black < lvl_white) ? lvl_white : lvl_black;
		case ($urandom_range(0, 9)) inside
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			2: begin
				return 16'(lvl_black + $urandom_range(0, 2) - 1);
			end
			3: begin
				return 16'(lvl_white + $urandom_range(0, 2) - 1);
			end
			8, 9: begin
				return 16'($urandom);
			end
			default: begin
				return 16'($urandom_range(lo, hi));
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.spi_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
		model_byte(b);
	endtask

	task automatic send_pixel(input logic [15:0] v);
		send_byte(v[15:8]);
		send_byte(v[7:0]);
	endtask

	task automatic finish_packet();
		while (frm_pos != 0) begin
			if (frm_pos >= HEADER_BYTES && (frm_pos - HEADER_BYTES) % 2 == 0) begin
				send_pixel(pick_pixel());
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	task automatic send_header(input logic [7:0] number);
		send_byte(8'($urandom));
		send_byte(number);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
	endtask

	task automatic send_packet(input logic [7:0] number);
		finish_packet();
		send_header(number);
		finish_packet();
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_level(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_BLACK) begin
			lvl_black = value;
		end else begin
			lvl_white = value;
		end
	endtask

	task automatic set_levels(input logic [15:0] black, input logic [15:0] white);
		wait_drained();
		write_level(CFG_BLACK, black);
		write_level(CFG_WHITE, white);
	endtask

	task automatic test_reset_levels();
		logic [15:0] probes [12];
		probes = '{16'd0, 16'd7799, 16'd7800, 16'd7801, 16'd8900, 16'd9999,
			16'd10000, 16'd10001, 16'd65535, 16'h5555, 16'hAAAA, 16'd8000};
		send_header(8'(frm_expect));
		foreach (probes[i]) begin
			send_pixel(probes[i]);
		end
		finish_packet();
	endtask

	task automatic test_packet_numbers();
		send_packet(8'(frm_expect + 1));
		send_packet(8'd5);
		send_packet(8'd0);
		send_packet(8'd255);
	endtask

	task automatic test_level_extremes();
		logic [15:0] blacks [8];
		logic [15:0] whites [8];
		blacks = '{16'd0, 16'd0, 16'd65535, 16'd65534, 16'd40000, 16'd12345, 16'd65535,
			16'd1000};
		whites = '{16'd65535, 16'd1, 16'd65535, 16'd65535, 16'd30000, 16'd12346, 16'd1,
			16'd1255};
		finish_packet();
		send_header(8'(frm_expect));
		foreach (blacks[i]) begin
			set_levels(blacks[i], whites[i]);
			repeat (8) send_pixel(pick_pixel());
		end
		finish_packet();
	endtask

	task automatic test_holdoff();
		jitter_on = 1'b0;
		ready_hold = HOLD_CYCLES;
		send_packet(8'(frm_expect));
		jitter_on = 1'b1;
	endtask

	task automatic pick_levels();
		int lo;
		int hi;
		case ($urandom_range(0, 3))
			0: begin
				lo = $urandom_range(0, 65535);
				hi = $urandom_range(1, 65535);
			end
			3: begin
				lo = $urandom_range(0, 65000);
				hi = lo + $urandom_range(1, 300);
			end
			default: begin
				lo = $urandom_range(0, 65534);
				hi = $urandom_range(lo + 1, 65535);
			end
		endcase
		set_levels(16'(lo), 16'(hi));
	endtask

	task automatic test_random_stream();
		int start;
		int r;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 12) begin
				pick_levels();
			end
			jitter_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_packet(8'(frm_expect));
			end else if (r < 85) begin
				send_packet(8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				send_packet(8'(frm_expect + 1));
			end else begin
				repeat ($urandom_range(1, 200)) send_byte(8'($urandom));
			end
		end
		jitter_on = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin : result_sink
		int stall;
		stall = 0;
		pixel_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				pixel_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pixel_ch.ready <= 1'b0;
			end else begin
				pixel_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : result_check
		pixel_result_t want;
		forever begin
			@(posedge clk);
			idle_cycles++;
			if (arst_n && byte_ch.valid && byte_ch.ready) begin
				idle_cycles = 0;
			end
			if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
				idle_cycles = 0;
				if (pending_pixels.size() == 0) begin
					$error("unexpected transaction: row %0d column %0d resync %0b",
						pixel_ch.row, pixel_ch.column, pixel_ch.resync);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("row", want.row, pixel_ch.row);
					check_field("column", want.column, pixel_ch.column);
					check_field("gray", want.gray, pixel_ch.gray);
					check_field("frame_end", want.frame_end, pixel_ch.frame_end);
					check_field("resync", want.resync, pixel_ch.resync);
				end
			end
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("thermal_packet_deframer_scaler test failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BLACK;
		cfg_data <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.spi_byte <= '0;
		lvl_black = BLACK_RESET;
		lvl_white = WHITE_RESET;
		frm_pos = 0;
		frm_expect = 0;
		frm_ok = 1'b0;
		frm_high = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_levels();
		test_packet_numbers();
		test_level_extremes();
		test_holdoff();
		test_random_stream();
		wait_drained();
		if (errors == 0) begin
			$display("thermal_packet_deframer_scaler test passed");
		end else begin
			$display("thermal_packet_deframer_scaler test failed");
		end
		$finish;
	end

endmodule
